/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the flight phase annunciator
// Phase codes, command codes, register indexes, register resets and the
// structs that pass between the submodules.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned PhaseW   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [PhaseW-1:0] {
    PH_PREFLIGHT       = 5'd0,
    PH_TAXI            = 5'd1,
    PH_TAKEOFF         = 5'd2,
    PH_CLIMB           = 5'd3,
    PH_CRUISE          = 5'd4,
    PH_ASCENT          = 5'd5,
    PH_ORBIT           = 5'd6,
    PH_REENTRY         = 5'd7,
    PH_APPROACH        = 5'd8,
    PH_LANDING         = 5'd9,
    PH_FAULT           = 5'd10,
    PH_ABORT_TAKEOFF   = 5'd11,
    PH_GO_AROUND       = 5'd12,
    PH_HOLDING_PATTERN = 5'd13,
    PH_DIVERT          = 5'd14,
    PH_SHALLOW_REENTRY = 5'd15,
    PH_POST_LANDING    = 5'd16,
    PH_THERMAL_OVLD    = 5'd17
  } phase_e;

  localparam logic [PhaseW-1:0] PhLastKnown = PH_THERMAL_OVLD;

  typedef enum logic {
    FUNC_TELEMETRY = 1'b0,
    FUNC_COMMAND   = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GROUND_ALT   = 3'd0,
    CFG_CLIMB_ALT    = 3'd1,
    CFG_CRUISE_ALT   = 3'd2,
    CFG_ORBIT_ALT    = 3'd3,
    CFG_LOW_ALTS     = 3'd4,
    CFG_THROTTLE_THR = 3'd5,
    CFG_VSPEED_THR   = 3'd6,
    CFG_AIRSPEED_THR = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] GroundAltRst   = 16'd10;
  localparam logic [24:0] ClimbAltRst    = 25'd500;
  localparam logic [24:0] CruiseAltRst   = 25'd30000;
  localparam logic [24:0] OrbitAltRst    = 25'd1000000;
  localparam logic [63:0] LowAltsRst     = 64'h0000_7530_0000_0096;
  localparam logic [31:0] ThrottleThrRst = 32'hF233_CC0D;
  localparam logic [47:0] VspeedThrRst   = 48'hFFCE_0032_0005;
  localparam logic [31:0] AirspeedThrRst = 32'h0005_0096;

  // threshold register file contents
  typedef struct packed {
    logic [15:0] ground_alt;
    logic [24:0] climb_alt;
    logic [24:0] cruise_alt;
    logic [24:0] orbit_alt;
    logic [63:0] low_alts;
    logic [31:0] throttle_thr;
    logic [47:0] vspeed_thr;
    logic [31:0] airspeed_thr;
  } cfg_t;

  // telemetry predicates used by the transition rules
  typedef struct packed {
    logic grounded;
    logic climbing;
    logic leveled;
    logic thr_gt_taxi;
    logic thr_gt_takeoff;
    logic thr_lt_abort;
    logic thr_gt_ascent;
    logic above_cruise;
    logic above_orbit;
    logic below_approach;
    logic below_flare;
    logic spd_lt_rollout;
    logic spd_lt_stopped;
    logic vs_lt_deorbit;
  } cond_t;

endpackage

/* rtl/fpa_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fpa_cfg_regs: threshold register file
// Eight write-only threshold registers, each truncated to its own width.
// ----------------------------------------------------------------------------
module fpa_cfg_regs import fpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GROUND_ALT:   cfg_d.ground_alt   = cfg_data_i[15:0];
        CFG_CLIMB_ALT:    cfg_d.climb_alt    = cfg_data_i[24:0];
        CFG_CRUISE_ALT:   cfg_d.cruise_alt   = cfg_data_i[24:0];
        CFG_ORBIT_ALT:    cfg_d.orbit_alt    = cfg_data_i[24:0];
        CFG_LOW_ALTS:     cfg_d.low_alts     = cfg_data_i[63:0];
        CFG_THROTTLE_THR: cfg_d.throttle_thr = cfg_data_i[31:0];
        CFG_VSPEED_THR:   cfg_d.vspeed_thr   = cfg_data_i[47:0];
        CFG_AIRSPEED_THR: cfg_d.airspeed_thr = cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_alt   <= GroundAltRst;
      cfg_q.climb_alt    <= ClimbAltRst;
      cfg_q.cruise_alt   <= CruiseAltRst;
      cfg_q.orbit_alt    <= OrbitAltRst;
      cfg_q.low_alts     <= LowAltsRst;
      cfg_q.throttle_thr <= ThrottleThrRst;
      cfg_q.vspeed_thr   <= VspeedThrRst;
      cfg_q.airspeed_thr <= AirspeedThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/fpa_eval.sv */
// ----------------------------------------------------------------------------
// fpa_eval: telemetry comparators
// Compares one telemetry frame against the thresholds, all in parallel.
// ----------------------------------------------------------------------------
module fpa_eval import fpa_pkg::*; (
  input  cfg_t                cfg_i,
  input  logic signed [25:0]  altitude_i,
  input  logic        [16:0]  airspeed_i,
  input  logic signed [17:0]  vspeed_i,
  input  logic        [7:0]   throttle_i,
  output cond_t               cond_o
);

  // altitudes compared on a common 34-bit signed scale
  logic signed [33:0] alt_x;
  logic signed [33:0] ground_x;
  logic signed [33:0] climb_x;
  logic signed [33:0] cruise_x;
  logic signed [33:0] orbit_x;
  logic signed [33:0] flare_x;
  logic signed [33:0] approach_x;
  logic        [17:0] abs_vs;
  logic signed [17:0] deorbit_x;
  logic               vs_pos;
  logic               gnd_alt_ok;
  logic               gnd_vs_ok;

  assign alt_x      = {{8{altitude_i[25]}}, altitude_i};
  assign ground_x   = $signed({18'd0, cfg_i.ground_alt});
  assign climb_x    = $signed({9'd0, cfg_i.climb_alt});
  assign cruise_x   = $signed({9'd0, cfg_i.cruise_alt});
  assign orbit_x    = $signed({9'd0, cfg_i.orbit_alt});
  assign flare_x    = $signed({2'd0, cfg_i.low_alts[31:0]});
  assign approach_x = $signed({2'd0, cfg_i.low_alts[63:32]});

  // magnitude of the most negative speed still fits as unsigned
  assign abs_vs    = vspeed_i[17] ? (~vspeed_i + 18'd1) : vspeed_i;
  assign deorbit_x = {{2{cfg_i.vspeed_thr[47]}}, cfg_i.vspeed_thr[47:32]};
  assign vs_pos    = !vspeed_i[17] && (|vspeed_i);

  assign gnd_alt_ok = alt_x <= ground_x;
  assign gnd_vs_ok  = abs_vs <= {2'd0, cfg_i.vspeed_thr[15:0]};

  always_comb begin
    cond_o.grounded       = gnd_alt_ok && gnd_vs_ok;
    cond_o.climbing       = (alt_x > climb_x) && vs_pos;
    cond_o.leveled        = abs_vs < {2'd0, cfg_i.vspeed_thr[31:16]};
    cond_o.thr_gt_taxi    = throttle_i > cfg_i.throttle_thr[7:0];
    cond_o.thr_gt_takeoff = throttle_i > cfg_i.throttle_thr[15:8];
    cond_o.thr_lt_abort   = throttle_i < cfg_i.throttle_thr[23:16];
    cond_o.thr_gt_ascent  = throttle_i > cfg_i.throttle_thr[31:24];
    cond_o.above_cruise   = alt_x > cruise_x;
    cond_o.above_orbit    = alt_x > orbit_x;
    cond_o.below_approach = alt_x < approach_x;
    cond_o.below_flare    = alt_x < flare_x;
    cond_o.spd_lt_rollout = airspeed_i < {1'b0, cfg_i.airspeed_thr[15:0]};
    cond_o.spd_lt_stopped = airspeed_i < {1'b0, cfg_i.airspeed_thr[31:16]};
    cond_o.vs_lt_deorbit  = vspeed_i < deorbit_x;
  end

endmodule

/* rtl/fpa_phase_logic.sv */
// ----------------------------------------------------------------------------
// fpa_phase_logic: phase transition rules
// Picks the next phase from the current one, the telemetry predicates or
// a forced phase command, and flags change and acceptance.
// ----------------------------------------------------------------------------
module fpa_phase_logic import fpa_pkg::*; (
  input  phase_e              phase_i,
  input  cond_t               cond_i,
  input  logic                func_i,
  input  logic [PhaseW-1:0]   requested_phase_i,
  output phase_e              phase_o,
  output logic                changed_o,
  output logic                accepted_o
);

  phase_e tel_phase;

  // first matching rule of the current phase wins
  always_comb begin
    tel_phase = phase_i;
    case (phase_i)
      PH_PREFLIGHT: begin
        if (cond_i.grounded && cond_i.thr_gt_taxi) tel_phase = PH_TAXI;
      end
      PH_TAXI: begin
        if (cond_i.grounded && cond_i.thr_gt_takeoff) tel_phase = PH_TAKEOFF;
      end
      PH_TAKEOFF: begin
        if (cond_i.climbing) tel_phase = PH_CLIMB;
        else if (cond_i.grounded && cond_i.thr_lt_abort) tel_phase = PH_ABORT_TAKEOFF;
      end
      PH_ABORT_TAKEOFF: begin
        if (cond_i.grounded && cond_i.spd_lt_rollout) tel_phase = PH_TAXI;
      end
      PH_CLIMB: begin
        if (cond_i.above_cruise && cond_i.leveled) tel_phase = PH_CRUISE;
      end
      PH_CRUISE: begin
        if (cond_i.thr_gt_ascent) tel_phase = PH_ASCENT;
      end
      PH_ASCENT: begin
        if (cond_i.above_orbit && cond_i.leveled) tel_phase = PH_ORBIT;
      end
      PH_ORBIT: begin
        if (cond_i.vs_lt_deorbit) tel_phase = PH_REENTRY;
      end
      PH_REENTRY: begin
        if (cond_i.below_approach) tel_phase = PH_APPROACH;
      end
      PH_APPROACH: begin
        if (!cond_i.grounded && cond_i.thr_gt_ascent) tel_phase = PH_GO_AROUND;
        else if (cond_i.below_flare) tel_phase = PH_LANDING;
      end
      PH_LANDING: begin
        if (!cond_i.grounded && cond_i.thr_gt_ascent) tel_phase = PH_GO_AROUND;
        else if (cond_i.grounded && cond_i.spd_lt_rollout) tel_phase = PH_POST_LANDING;
      end
      PH_GO_AROUND: begin
        if (cond_i.climbing) tel_phase = PH_CLIMB;
      end
      PH_POST_LANDING: begin
        if (cond_i.spd_lt_stopped) tel_phase = PH_TAXI;
      end
      default: tel_phase = phase_i;  // phases without rules hold
    endcase
  end

  always_comb begin
    if (func_e'(func_i) == FUNC_COMMAND) begin
      changed_o = 1'b1;
      if (requested_phase_i > PhLastKnown) begin
        phase_o    = PH_FAULT;
        accepted_o = 1'b0;
      end else begin
        phase_o    = phase_e'(requested_phase_i);
        accepted_o = 1'b1;
      end
    end else begin
      phase_o    = tel_phase;
      changed_o  = tel_phase != phase_i;
      accepted_o = 1'b1;
    end
  end

endmodule

/* rtl/flight_phase_annunciator_unit.sv */
// ----------------------------------------------------------------------------
// flight_phase_annunciator_unit: phase-of-flight annunciator
// Input register, comparators and rule logic, result register. The phase
// state updates when an item moves into the result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | sink      | in_valid_i/in_stall_o  | func, altitude, airspeed,
//           |           |                        | vspeed, throttle,
//           |           |                        | requested_phase
//   out     | source    | out_valid_o/out_stall_i| phase, previous_phase,
//           |           |                        | changed, accepted
//   cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One item per cycle while the output does not stall; an item passes the input
// register, then the result register. The phase register loops via compare and
// rule logic only, so back-to-back items see each other's phase with no gap.
// Reset: phase PREFLIGHT, thresholds at their defaults, both stages empty.
// A stalled output holds the result; the input stalls only when its stage
// is full and cannot move on.
// ----------------------------------------------------------------------------
module flight_phase_annunciator_unit import fpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic signed [25:0]  altitude_i,
  input  logic        [16:0]  airspeed_i,
  input  logic signed [17:0]  vspeed_i,
  input  logic        [7:0]   throttle_i,
  input  logic [PhaseW-1:0]   requested_phase_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PhaseW-1:0]   phase_o,
  output logic [PhaseW-1:0]   previous_phase_o,
  output logic                changed_o,
  output logic                accepted_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t   cfg;
  cond_t  cond;
  phase_e next_phase;
  logic   next_changed;
  logic   next_accepted;

  // input stage
  logic                in_valid_q;
  logic                in_valid_d;
  logic                func_q;
  logic signed [25:0]  altitude_q;
  logic        [16:0]  airspeed_q;
  logic signed [17:0]  vspeed_q;
  logic        [7:0]   throttle_q;
  logic [PhaseW-1:0]   req_q;

  // state and result stage
  phase_e phase_q;
  phase_e phase_d;
  logic   out_valid_q;
  logic   out_valid_d;
  phase_e res_phase_q;
  phase_e res_prev_q;
  logic   res_changed_q;
  logic   res_accepted_q;

  logic in_xfer;
  logic advance;
  logic out_hold;

  assign out_hold   = out_valid_q && out_stall_i;
  assign advance    = in_valid_q && !out_hold;
  assign in_stall_o = in_valid_q && out_hold;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || out_hold;
  assign phase_d     = advance ? next_phase : phase_q;

  fpa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fpa_eval u_eval (
    .cfg_i      (cfg),
    .altitude_i (altitude_q),
    .airspeed_i (airspeed_q),
    .vspeed_i   (vspeed_q),
    .throttle_i (throttle_q),
    .cond_o     (cond)
  );

  fpa_phase_logic u_rules (
    .phase_i           (phase_q),
    .cond_i            (cond),
    .func_i            (func_q),
    .requested_phase_i (req_q),
    .phase_o           (next_phase),
    .changed_o         (next_changed),
    .accepted_o        (next_accepted)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_PREFLIGHT;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q     <= func_i;
      altitude_q <= altitude_i;
      airspeed_q <= airspeed_i;
      vspeed_q   <= vspeed_i;
      throttle_q <= throttle_i;
      req_q      <= requested_phase_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_phase_q    <= next_phase;
      res_prev_q     <= phase_q;
      res_changed_q  <= next_changed;
      res_accepted_q <= next_accepted;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = res_phase_q;
  assign previous_phase_o = res_prev_q;
  assign changed_o        = res_changed_q;
  assign accepted_o       = res_accepted_q;

  // result register tracks the phase state right after each load
  a_phase_tracks_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_phase_q == phase_q))
    else $error("result phase differs from phase state");

  // a rejected command always lands in FAULT and counts as a change
  a_reject_is_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_accepted_q) |-> (res_phase_q == PH_FAULT && res_changed_q))
    else $error("rejected command without FAULT");

  // no change flagged means the phase stayed put
  a_unchanged_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_changed_q) |-> (res_phase_q == res_prev_q))
    else $error("phase moved without change flag");

  // phase state moves only when an item enters the result register
  a_phase_only_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q))
    else $error("phase state moved without an item");

  // input stage never drops an item while the output is stalled
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_hold) |=> (in_valid_q && $stable(func_q) && $stable(req_q)))
    else $error("input stage overwritten while stalled");

endmodule
